// ===== rtl/assert_macros.svh =====
// concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/alb_pkg.sv =====
`default_nettype none

package alb_pkg;

    localparam int BITS_PER_PIXEL = 24;
    localparam int CNT_W          = $clog2(BITS_PER_PIXEL + 1);
    localparam int QDEPTH         = 2;
    localparam int QPTR_W         = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W         = $clog2(QDEPTH + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [QPTR_W-1:0] t_qptr;
    typedef logic [QCNT_W-1:0] t_qcnt;

    localparam t_cnt CNT_LAST_CELL = t_cnt'(BITS_PER_PIXEL - 1);
    localparam t_cnt CNT_LATCH     = t_cnt'(BITS_PER_PIXEL);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BRIGHTNESS   = 3'd0,
        REG_GREEN_FIRST  = 3'd1,
        REG_ZERO_HIGH    = 3'd2,
        REG_ONE_HIGH     = 3'd3,
        REG_CELL_LENGTH  = 3'd4,
        REG_LATCH_LOW    = 3'd5
    } t_reg_idx;

    localparam logic [7:0]  RST_BRIGHTNESS  = 8'd255;
    localparam logic        RST_GREEN_FIRST = 1'b1;
    localparam logic [11:0] RST_ZERO_HIGH   = 12'd30;
    localparam logic [11:0] RST_ONE_HIGH    = 12'd90;
    localparam logic [11:0] RST_CELL_LENGTH = 12'd120;
    localparam logic [19:0] RST_LATCH_LOW   = 20'd28000;

    typedef struct packed {
        logic [7:0]  brightness;
        logic        green_first_order;
        logic [11:0] zero_high_cycles;
        logic [11:0] one_high_cycles;
        logic [11:0] cell_length_cycles;
        logic [19:0] latch_low_cycles;
    } t_cfg;

    typedef struct packed {
        logic [BITS_PER_PIXEL-1:0] word;
        logic                      eof;
        logic                      dark;
    } t_pix;

    // exact floor(p / 255) for any 16-bit p whose quotient fits a byte
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] s;
        s = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
        return s[15:8];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/alb_front.sv =====
`default_nettype none

module alb_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire alb_pkg::t_cfg i_cfg,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [7:0]    i_red,
    input  wire logic [7:0]    i_green,
    input  wire logic [7:0]    i_blue,
    input  wire logic          i_end_of_frame,
    output logic               o_push_valid,
    input  wire logic          i_push_ready,
    output alb_pkg::t_pix      o_push_data
);

    logic        r_s1_valid;
    logic [15:0] r_prod_r;
    logic [15:0] r_prod_g;
    logic [15:0] r_prod_b;
    logic        r_eof;
    logic        r_any_lit;

    logic [7:0]  sc_r;
    logic [7:0]  sc_g;
    logic [7:0]  sc_b;
    logic        n_lit;
    logic        push_fire;

    assign o_in_ready = !r_s1_valid || i_push_ready;
    assign push_fire  = r_s1_valid && i_push_ready;

    // stage 1: channel products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_prod_r <= 16'(i_red   * i_cfg.brightness);
            r_prod_g <= 16'(i_green * i_cfg.brightness);
            r_prod_b <= 16'(i_blue  * i_cfg.brightness);
            r_eof    <= i_end_of_frame;
        end
    end

    // stage 2: divide by 255, byte order, dark tracking
    always_comb begin
        sc_r  = alb_pkg::div255(r_prod_r);
        sc_g  = alb_pkg::div255(r_prod_g);
        sc_b  = alb_pkg::div255(r_prod_b);
        n_lit = r_any_lit || (sc_r != 8'd0) || (sc_g != 8'd0) || (sc_b != 8'd0);
        if (i_cfg.green_first_order) begin
            o_push_data.word = {sc_g, sc_r, sc_b};
        end else begin
            o_push_data.word = {sc_r, sc_g, sc_b};
        end
        o_push_data.eof  = r_eof;
        o_push_data.dark = !n_lit;
    end

    assign o_push_valid = r_s1_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any_lit <= 1'b0;
        end else if (push_fire) begin
            r_any_lit <= r_eof ? 1'b0 : n_lit;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/alb_queue.sv =====
`default_nettype none

module alb_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push_valid,
    output logic               o_push_ready,
    input  wire alb_pkg::t_pix i_push_data,
    output logic               o_pop_valid,
    input  wire logic          i_pop_ready,
    output alb_pkg::t_pix      o_pop_data
);

    alb_pkg::t_pix r_mem [alb_pkg::QDEPTH];
    alb_pkg::t_qptr r_wr_ptr;
    alb_pkg::t_qptr r_rd_ptr;
    alb_pkg::t_qcnt r_count;

    logic push;
    logic pop;

    assign o_push_ready = (r_count != alb_pkg::t_qcnt'(alb_pkg::QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    function automatic alb_pkg::t_qptr ptr_inc(input alb_pkg::t_qptr p);
        if (p == alb_pkg::t_qptr'(alb_pkg::QDEPTH - 1)) begin
            return '0;
        end
        return p + alb_pkg::t_qptr'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + alb_pkg::t_qcnt'(1);
            end else if (pop && !push) begin
                r_count <= r_count - alb_pkg::t_qcnt'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/alb_back.sv =====
`default_nettype none

module alb_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire alb_pkg::t_cfg i_cfg,
    input  wire logic          i_pop_valid,
    output logic               o_pop_ready,
    input  wire alb_pkg::t_pix i_pop_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [11:0]        o_high_cycles,
    output logic [19:0]        o_cell_cycles,
    output logic               o_bit_value,
    output logic               o_is_latch,
    output logic               o_frame_dark,
    output logic               o_last
);

    logic                               r_busy;
    logic [alb_pkg::BITS_PER_PIXEL-1:0] r_word;
    alb_pkg::t_cnt                      r_cnt;
    logic                               r_eof;
    logic                               r_dark;

    logic        r_ov;
    logic [11:0] r_high;
    logic [19:0] r_cell;
    logic        r_bit;
    logic        r_latch;
    logic        r_fdark;
    logic        r_last;

    logic        adv;
    logic        finishing;
    logic        load;
    logic        in_latch;
    logic        cur_bit;
    logic [11:0] n_high;
    logic [11:0] n_cell12;

    assign in_latch  = (r_cnt == alb_pkg::CNT_LATCH);
    assign adv       = r_busy && (!r_ov || i_out_ready);
    assign finishing = adv && (in_latch || ((r_cnt == alb_pkg::CNT_LAST_CELL) && !r_eof));
    assign load      = i_pop_valid && (!r_busy || finishing);
    assign o_pop_ready = !r_busy || finishing;

    always_comb begin
        cur_bit  = r_word[alb_pkg::BITS_PER_PIXEL-1];
        n_high   = cur_bit ? i_cfg.one_high_cycles : i_cfg.zero_high_cycles;
        n_cell12 = (i_cfg.cell_length_cycles > n_high) ? i_cfg.cell_length_cycles : n_high;
    end

    // bit walker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (finishing) begin
            r_busy <= 1'b0;
        end else if (adv) begin
            r_cnt  <= r_cnt + alb_pkg::t_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= i_pop_data.word;
            r_eof  <= i_pop_data.eof;
            r_dark <= i_pop_data.dark;
        end else if (adv) begin
            r_word <= {r_word[alb_pkg::BITS_PER_PIXEL-2:0], 1'b0};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (in_latch) begin
                r_high  <= 12'd0;
                r_cell  <= i_cfg.latch_low_cycles;
                r_bit   <= 1'b0;
                r_latch <= 1'b1;
                r_fdark <= r_dark;
                r_last  <= 1'b1;
            end else begin
                r_high  <= n_high;
                r_cell  <= {8'd0, n_cell12};
                r_bit   <= cur_bit;
                r_latch <= 1'b0;
                r_fdark <= 1'b0;
                r_last  <= (r_cnt == alb_pkg::CNT_LAST_CELL) && !r_eof;
            end
        end
    end

    assign o_out_valid   = r_ov;
    assign o_high_cycles = r_high;
    assign o_cell_cycles = r_cell;
    assign o_bit_value   = r_bit;
    assign o_is_latch    = r_latch;
    assign o_frame_dark  = r_fdark;
    assign o_last        = r_last;

endmodule

`default_nettype wire

// ===== rtl/addressable_led_bit_serializer_core.sv =====
// channel   direction  handshake                  payload
// pixel     in         i_in_valid / o_in_ready    i_red i_green i_blue i_end_of_frame
// cell      out        o_out_valid / i_out_ready  o_high_cycles o_cell_cycles o_bit_value
//                                                 o_is_latch o_frame_dark o_last
// config    in         i_cfg_we                   i_cfg_index i_cfg_data
//
// a pixel is 24 cells, 25 with end of frame; the back emits one cell per cycle unless stalled
// the front scales through a register into a two-entry queue, so pixels are taken ahead
// reset is synchronous; it empties the pipeline and restores register defaults
// a stalled output holds the serializer; a full queue stalls the input when stage 1 is full

`default_nettype none

`include "assert_macros.svh"

module addressable_led_bit_serializer_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [alb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [alb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [7:0]                      i_red,
    input  wire logic [7:0]                      i_green,
    input  wire logic [7:0]                      i_blue,
    input  wire logic                            i_end_of_frame,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [11:0]                          o_high_cycles,
    output logic [19:0]                          o_cell_cycles,
    output logic                                 o_bit_value,
    output logic                                 o_is_latch,
    output logic                                 o_frame_dark,
    output logic                                 o_last
);

    alb_pkg::t_cfg r_cfg;
    alb_pkg::t_pix push_data;
    alb_pkg::t_pix pop_data;
    logic          push_valid;
    logic          push_ready;
    logic          pop_valid;
    logic          pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brightness         <= alb_pkg::RST_BRIGHTNESS;
            r_cfg.green_first_order  <= alb_pkg::RST_GREEN_FIRST;
            r_cfg.zero_high_cycles   <= alb_pkg::RST_ZERO_HIGH;
            r_cfg.one_high_cycles    <= alb_pkg::RST_ONE_HIGH;
            r_cfg.cell_length_cycles <= alb_pkg::RST_CELL_LENGTH;
            r_cfg.latch_low_cycles   <= alb_pkg::RST_LATCH_LOW;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                alb_pkg::REG_BRIGHTNESS: begin
                    r_cfg.brightness <= i_cfg_data[7:0];
                end
                alb_pkg::REG_GREEN_FIRST: begin
                    r_cfg.green_first_order <= i_cfg_data[0];
                end
                alb_pkg::REG_ZERO_HIGH: begin
                    r_cfg.zero_high_cycles <= i_cfg_data[11:0];
                end
                alb_pkg::REG_ONE_HIGH: begin
                    r_cfg.one_high_cycles <= i_cfg_data[11:0];
                end
                alb_pkg::REG_CELL_LENGTH: begin
                    r_cfg.cell_length_cycles <= i_cfg_data[11:0];
                end
                alb_pkg::REG_LATCH_LOW: begin
                    r_cfg.latch_low_cycles <= i_cfg_data[19:0];
                end
                default: begin
                end
            endcase
        end
    end

    alb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_end_of_frame (i_end_of_frame),
        .o_push_valid   (push_valid),
        .i_push_ready   (push_ready),
        .o_push_data    (push_data)
    );

    alb_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    alb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_pop_valid   (pop_valid),
        .o_pop_ready   (pop_ready),
        .i_pop_data    (pop_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_high_cycles (o_high_cycles),
        .o_cell_cycles (o_cell_cycles),
        .o_bit_value   (o_bit_value),
        .o_is_latch    (o_is_latch),
        .o_frame_dark  (o_frame_dark),
        .o_last        (o_last)
    );

    `ASSERT_SAME_CYCLE(a_latch_ends_request, i_clk, i_rst_n, o_out_valid && o_is_latch, o_last && (o_high_cycles == 12'd0) && !o_bit_value)
    `ASSERT_SAME_CYCLE(a_dark_only_on_latch, i_clk, i_rst_n, o_out_valid && !o_is_latch, !o_frame_dark)
    `ASSERT_NEXT_CYCLE(a_front_holds_on_full, i_clk, i_rst_n, push_valid && !push_ready, push_valid && $stable(push_data.eof))

endmodule

`default_nettype wire
